// File: rtl/core/arc_pkg.sv
// Shared types and constants of the adaptive Rice decoder.
// No dependencies; every other file of the core imports it.
package arc_pkg;

    localparam int BYTE_W          = 8;
    localparam int BIT_CNT_W       = $clog2(BYTE_W);
    localparam int VALUE_W         = 32;
    localparam int INIT_K_W        = 5;
    localparam int ADDR_W          = 4;
    localparam int DATA_W          = 32;

    localparam int DEF_MAX_K       = 16;
    localparam int DEF_VALUE_BITS  = 32;
    localparam int DEF_PREFIX_BITS = 16;

    typedef enum logic [1:0] {
        REG_INITIAL_K    = 2'd0,
        REG_ADAPT_ENABLE = 2'd1,
        REG_SIGNED_MODE  = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BITS,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [INIT_K_W-1:0] initial_k;
        logic                adapt_enable;
        logic                signed_mode;
        logic                k_load;
    } cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
        logic flush;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic emit_now;
        logic pend_valid;
        logic out_free;
    } stat_t;

endpackage

// File: rtl/core/arc_byte_if.sv
// Input channel of the adaptive Rice decoder: one compressed byte per beat.
// Depends on arc_pkg.
interface arc_byte_if import arc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] code_byte;
    logic              restart;

    modport source (output valid, output code_byte, output restart, input ready);
    modport sink   (input valid, input code_byte, input restart, output ready);
endinterface

// File: rtl/core/arc_code_if.sv
// Output channel of the adaptive Rice decoder: one decoded code per beat.
// Depends on arc_pkg.
interface arc_code_if import arc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               overflow;
    logic               last_of_byte;

    modport source (output valid, output value, output overflow, output last_of_byte,
                    input ready);
    modport sink   (input valid, input value, input overflow, input last_of_byte,
                    output ready);
endinterface

// File: rtl/core/arc_cfg.sv
// APB register block: initial_k, adapt_enable, signed_mode.
// Depends on arc_pkg.
module arc_cfg import arc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [INIT_K_W-1:0] initial_k_reg, initial_k_next;
    logic                adapt_reg, adapt_next;
    logic                signed_reg, signed_next;
    logic                k_load_reg, k_load_next;
    logic                wr;
    reg_idx_t            idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        initial_k_next = initial_k_reg;
        adapt_next     = adapt_reg;
        signed_next    = signed_reg;
        k_load_next    = 1'b0;
        if (wr)
        begin
            case (idx)
                REG_INITIAL_K:
                begin
                    initial_k_next = pwdata[INIT_K_W-1:0];
                    k_load_next    = 1'b1;
                end
                REG_ADAPT_ENABLE: adapt_next  = pwdata[0];
                REG_SIGNED_MODE:  signed_next = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_INITIAL_K:    prdata = DATA_W'(initial_k_reg);
            REG_ADAPT_ENABLE: prdata = DATA_W'(adapt_reg);
            REG_SIGNED_MODE:  prdata = DATA_W'(signed_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_k_reg <= '0;
            adapt_reg     <= 1'b1;
            signed_reg    <= 1'b0;
            k_load_reg    <= 1'b0;
        end
        else
        begin
            initial_k_reg <= initial_k_next;
            adapt_reg     <= adapt_next;
            signed_reg    <= signed_next;
            k_load_reg    <= k_load_next;
        end
    end

    // k_load rises in the cycle after the write, when initial_k holds the new value
    assign cfg.initial_k    = initial_k_reg;
    assign cfg.adapt_enable = adapt_reg;
    assign cfg.signed_mode  = signed_reg;
    assign cfg.k_load       = k_load_reg;

endmodule

// File: rtl/core/arc_ctrl.sv
// Byte sequencer: accepts a byte, steps its eight bits, flushes the held code.
// Depends on arc_pkg.
module arc_ctrl import arc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t                 state_reg, state_next;
    logic [BIT_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   flush_ok;

    assign flush_ok = !stat.pend_valid || stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = BIT_CNT_W'(BYTE_W - 1);
                    state_next = ST_BITS;
                end
            end
            ST_BITS:
            begin
                // hold the bit while a second code would need a busy output register
                if (!(stat.emit_now && stat.pend_valid && !stat.out_free))
                begin
                    cmd.step = 1'b1;
                    if (cnt_reg == '0)
                        state_next = ST_FLUSH;
                    else
                        cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (flush_ok)
                begin
                    cmd.flush = stat.pend_valid;
                    in_ready  = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        cnt_next   = BIT_CNT_W'(BYTE_W - 1);
                        state_next = ST_BITS;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: rtl/core/arc_dp.sv
// Datapath: bit shifter, prefix/remainder state, k adaptation, held code and
// output register.  Depends on arc_pkg and arc_code_if.
module arc_dp import arc_pkg::*;
#(
    parameter int MAX_K       = DEF_MAX_K,
    parameter int VALUE_BITS  = DEF_VALUE_BITS,
    parameter int PREFIX_BITS = DEF_PREFIX_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic [BYTE_W-1:0] code_byte,
    input  logic              restart,
    arc_code_if.source        codes
);

    localparam int K_W    = $clog2(MAX_K + 1);
    localparam int LOG_W  = $clog2(PREFIX_BITS);
    localparam int SUM_W  = K_W + LOG_W;
    localparam int FULL_W = PREFIX_BITS + MAX_K + VALUE_BITS;

    function automatic logic [LOG_W-1:0] flog2(input logic [PREFIX_BITS-1:0] x);
        logic [LOG_W-1:0] n;
        n = '0;
        for (int i = 1; i < PREFIX_BITS; i++)
        begin
            if (x[i])
                n = LOG_W'(i);
        end
        return n;
    endfunction

    logic [BYTE_W-1:0]      byte_reg, byte_next;
    logic [K_W-1:0]         cur_k_reg, cur_k_next;
    logic [K_W-1:0]         code_k_reg, code_k_next;
    logic [PREFIX_BITS-1:0] prefix_reg, prefix_next;
    logic [MAX_K-1:0]       rem_reg, rem_next;
    logic [K_W-1:0]         left_reg, left_next;
    logic                   in_rem_reg, in_rem_next;
    logic                   ovf_seen_reg, ovf_seen_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [VALUE_W-1:0]     pend_value_reg, pend_value_next;
    logic                   pend_ovf_reg, pend_ovf_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]     out_value_reg, out_value_next;
    logic                   out_ovf_reg, out_ovf_next;
    logic                   out_last_reg, out_last_next;

    logic                   bit_in;
    logic [K_W-1:0]         init_k_clamped;
    logic [K_W-1:0]         kk;
    logic [MAX_K:0]         rem_cat;
    logic [MAX_K-1:0]       rem_shift;
    logic                   emit_now;
    logic                   out_free;
    logic [K_W-1:0]         ek;
    logic [MAX_K-1:0]       erem;
    logic [FULL_W-1:0]      full;
    logic                   new_ovf;
    logic [VALUE_BITS-1:0]  u;
    logic [VALUE_BITS-1:0]  zz;
    logic [VALUE_W-1:0]     new_value;
    logic [LOG_W-1:0]       lg;
    logic [SUM_W-1:0]       nk;
    logic [K_W-1:0]         k_up;
    logic [K_W-1:0]         k_adapted;

    assign bit_in         = byte_reg[BYTE_W-1];
    assign init_k_clamped = (cfg.initial_k > INIT_K_W'(MAX_K)) ? K_W'(MAX_K)
                                                              : cfg.initial_k[K_W-1:0];
    assign kk             = cfg.adapt_enable ? cur_k_reg : init_k_clamped;
    assign rem_cat        = {rem_reg, bit_in};
    assign rem_shift      = rem_cat[MAX_K-1:0];
    assign emit_now       = in_rem_reg ? (left_reg == K_W'(1)) : (!bit_in && (kk == '0));
    assign out_free       = !out_valid_reg || codes.ready;

    // value of the code that closes on this bit
    assign ek        = in_rem_reg ? code_k_reg : '0;
    assign erem      = in_rem_reg ? rem_shift : '0;
    assign full      = (FULL_W'(prefix_reg) << ek) | FULL_W'(erem);
    assign new_ovf   = ovf_seen_reg || (|full[FULL_W-1:VALUE_BITS]);
    assign u         = full[VALUE_BITS-1:0];
    assign zz        = (u >> 1) ^ {VALUE_BITS{u[0]}};
    assign new_value = cfg.signed_mode ? VALUE_W'($signed(zz)) : VALUE_W'(u);

    // k after the code: down on q == 0, up by floor(log2 q) on q > 1
    assign lg   = flog2(prefix_reg);
    assign nk   = SUM_W'(cur_k_reg) + SUM_W'(lg);
    assign k_up = (nk > SUM_W'(MAX_K)) ? K_W'(MAX_K) : nk[K_W-1:0];

    always_comb
    begin
        k_adapted = cur_k_reg;
        if (prefix_reg == '0)
        begin
            if (cur_k_reg != '0)
                k_adapted = cur_k_reg - 1'b1;
        end
        else if (|prefix_reg[PREFIX_BITS-1:1])
        begin
            k_adapted = k_up;
        end
    end

    always_comb
    begin
        byte_next       = byte_reg;
        cur_k_next      = cur_k_reg;
        code_k_next     = code_k_reg;
        prefix_next     = prefix_reg;
        rem_next        = rem_reg;
        left_next       = left_reg;
        in_rem_next     = in_rem_reg;
        ovf_seen_next   = ovf_seen_reg;
        pend_valid_next = pend_valid_reg;
        pend_value_next = pend_value_reg;
        pend_ovf_next   = pend_ovf_reg;
        out_valid_next  = out_valid_reg && !codes.ready;
        out_value_next  = out_value_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;

        if (cfg.k_load)
            cur_k_next = init_k_clamped;

        if (cmd.load)
        begin
            byte_next = code_byte;
            if (restart)
            begin
                cur_k_next    = init_k_clamped;
                prefix_next   = '0;
                rem_next      = '0;
                left_next     = '0;
                in_rem_next   = 1'b0;
                ovf_seen_next = 1'b0;
            end
        end

        if (cmd.step)
        begin
            byte_next = byte_reg << 1;
            if (!in_rem_reg)
            begin
                if (bit_in)
                begin
                    if (prefix_reg == '1)
                        ovf_seen_next = 1'b1;
                    else
                        prefix_next = prefix_reg + 1'b1;
                end
                else
                begin
                    code_k_next = kk;
                    if (kk != '0)
                    begin
                        in_rem_next = 1'b1;
                        left_next   = kk;
                        rem_next    = '0;
                    end
                end
            end
            else
            begin
                rem_next  = rem_shift;
                left_next = left_reg - 1'b1;
            end

            if (emit_now)
            begin
                if (cfg.adapt_enable)
                    cur_k_next = k_adapted;
                prefix_next   = '0;
                rem_next      = '0;
                left_next     = '0;
                in_rem_next   = 1'b0;
                ovf_seen_next = 1'b0;
                // the held code is not the last of the byte: send it on
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = pend_value_reg;
                    out_ovf_next   = pend_ovf_reg;
                    out_last_next  = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_value_next = new_value;
                pend_ovf_next   = new_ovf;
            end
        end

        if (cmd.flush)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = pend_value_reg;
            out_ovf_next    = pend_ovf_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_k_reg      <= '0;
            prefix_reg     <= '0;
            left_reg       <= '0;
            in_rem_reg     <= 1'b0;
            ovf_seen_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cur_k_reg      <= cur_k_next;
            prefix_reg     <= prefix_next;
            left_reg       <= left_next;
            in_rem_reg     <= in_rem_next;
            ovf_seen_reg   <= ovf_seen_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        code_k_reg     <= code_k_next;
        rem_reg        <= rem_next;
        pend_value_reg <= pend_value_next;
        pend_ovf_reg   <= pend_ovf_next;
        out_value_reg  <= out_value_next;
        out_ovf_reg    <= out_ovf_next;
        out_last_reg   <= out_last_next;
    end

    assign stat.emit_now   = emit_now;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = out_free;

    assign codes.valid        = out_valid_reg;
    assign codes.value        = out_value_reg;
    assign codes.overflow     = out_ovf_reg;
    assign codes.last_of_byte = out_last_reg;

`ifndef SYNTHESIS
    a_no_clobber_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && emit_now && pend_valid_reg) |-> out_free)
        else $error("code emitted while output register busy");

    a_flush_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> (pend_valid_reg && out_free))
        else $error("flush without held code or free output register");

    a_rem_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        in_rem_reg |-> (left_reg != '0))
        else $error("remainder phase with no bits left");

    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_k_reg <= K_W'(MAX_K)) && (code_k_reg <= K_W'(MAX_K) || !in_rem_reg))
        else $error("k beyond MAX_K");

    a_flush_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> (out_valid_reg && out_last_reg))
        else $error("flushed code not marked last of byte");
`endif

endmodule

// File: rtl/core/adaptive_rice_decoder_core.sv
// Top level of the adaptive Rice decoder: APB registers, sequencer, datapath.
// Depends on arc_pkg, arc_byte_if, arc_code_if, arc_cfg, arc_ctrl, arc_dp.
//
//   channel   dir   beat                                   handshake
//   bytes     in    code_byte[7:0], restart                valid/ready
//   codes     out   value[31:0], overflow, last_of_byte    valid/ready
//   apb       in    initial_k, adapt_enable, signed_mode   psel/penable, pready=1
//
// A byte is accepted, then its bits are stepped one bit per cycle, unless stalled,
// through the shared bit-step datapath.  Codes are held one deep so the last of a byte
// can be flagged; a busy output register stalls the bit step.  Async reset
// clears control state; k returns to 0, adaptation on, unsigned mode.
module adaptive_rice_decoder_core import arc_pkg::*;
#(
    parameter int MAX_K       = DEF_MAX_K,
    parameter int VALUE_BITS  = DEF_VALUE_BITS,
    parameter int PREFIX_BITS = DEF_PREFIX_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    arc_byte_if.sink          bytes,
    arc_code_if.source        codes
);

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;
    logic  in_ready;

    assign bytes.ready = in_ready;

    arc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    arc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (bytes.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    arc_dp #(
        .MAX_K       (MAX_K),
        .VALUE_BITS  (VALUE_BITS),
        .PREFIX_BITS (PREFIX_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .stat      (stat),
        .code_byte (bytes.code_byte),
        .restart   (bytes.restart),
        .codes     (codes)
    );

endmodule
